// File: hdl/dcfp_pkg.sv
// Package for the drive command frame parser.
// Holds character codes, register indexes, limits and result types; no dependencies.
package dcfp_pkg;

  localparam int FIELD_COUNT = 3;
  localparam int SLOT_W      = $clog2(FIELD_COUNT);
  localparam int ACC_W       = 16;
  localparam int SPEED_W     = 8;
  localparam int DIR_W       = 9;
  localparam int SPIN_W      = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  localparam slot_idx_t SLOT_FIRST = slot_idx_t'(0);
  localparam slot_idx_t SLOT_LAST  = slot_idx_t'(FIELD_COUNT - 1);

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_END   = 8'h45;
  localparam logic [7:0] CHAR_STOP  = 8'h46;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIRECTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPIN      = 2'd2;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST     = 8'd21;
  localparam logic [DIR_W-1:0]   MAX_DIRECTION_RST = 9'd360;
  localparam logic [SPIN_W-1:0]  MAX_SPIN_RST      = 9'd360;

  typedef struct packed {
    logic [SPEED_W-1:0] max_speed;
    logic [DIR_W-1:0]   max_direction;
    logic [SPIN_W-1:0]  max_spin;
  } limits_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [DIR_W-1:0]   direction;
    logic [SPIN_W-1:0]  spin;
    logic               frame_done;
    logic               frame_rejected;
    logic               emergency_stop;
  } result_t;

endpackage

// File: hdl/dcfp_cfg_regs.sv
// Limit registers of the drive command frame parser.
// Depends on dcfp_pkg.
module dcfp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dcfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dcfp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dcfp_pkg::limits_t                  limits
);

  dcfp_pkg::limits_t limits_r;
  dcfp_pkg::limits_t limits_nxt;

  assign cfg_ready = 1'b1;
  assign limits    = limits_r;

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_valid) begin
      case (cfg_index)
        dcfp_pkg::CFG_MAX_SPEED:     limits_nxt.max_speed =
                                       cfg_data[dcfp_pkg::SPEED_W-1:0];
        dcfp_pkg::CFG_MAX_DIRECTION: limits_nxt.max_direction =
                                       cfg_data[dcfp_pkg::DIR_W-1:0];
        dcfp_pkg::CFG_MAX_SPIN:      limits_nxt.max_spin =
                                       cfg_data[dcfp_pkg::SPIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.max_speed     <= dcfp_pkg::MAX_SPEED_RST;
      limits_r.max_direction <= dcfp_pkg::MAX_DIRECTION_RST;
      limits_r.max_spin      <= dcfp_pkg::MAX_SPIN_RST;
    end else begin
      limits_r <= limits_nxt;
    end
  end

endmodule

// File: hdl/dcfp_frame_core.sv
// Frame state and per-byte update: accumulator, field slots, current command.
// Depends on dcfp_pkg.
module dcfp_frame_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  input  dcfp_pkg::limits_t limits,
  output dcfp_pkg::result_t result
);

  localparam int PROD_W = dcfp_pkg::ACC_W + 4;

  logic [dcfp_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic [dcfp_pkg::DIR_W-1:0]   direction_r, direction_nxt;
  logic [dcfp_pkg::SPIN_W-1:0]  spin_r, spin_nxt;
  logic [dcfp_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [dcfp_pkg::ACC_W-1:0]   slot_r   [dcfp_pkg::FIELD_COUNT];
  logic [dcfp_pkg::ACC_W-1:0]   slot_nxt [dcfp_pkg::FIELD_COUNT];
  dcfp_pkg::slot_idx_t          slot_ptr_r, slot_ptr_nxt;

  logic [PROD_W-1:0] acc_ext;
  logic [PROD_W-1:0] acc_prod;
  logic              over_limit;
  logic              done, rejected, estop;

  assign acc_ext  = {4'd0, acc_r};
  assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + {{(PROD_W-4){1'b0}}, rx_byte[3:0]};

  assign over_limit =
    (slot_r[0] > {{(dcfp_pkg::ACC_W-dcfp_pkg::SPEED_W){1'b0}}, limits.max_speed}) ||
    (slot_r[1] > {{(dcfp_pkg::ACC_W-dcfp_pkg::DIR_W){1'b0}}, limits.max_direction}) ||
    (slot_r[2] > {{(dcfp_pkg::ACC_W-dcfp_pkg::SPIN_W){1'b0}}, limits.max_spin});

  always_comb begin
    speed_nxt     = speed_r;
    direction_nxt = direction_r;
    spin_nxt      = spin_r;
    acc_nxt       = acc_r;
    slot_nxt      = slot_r;
    slot_ptr_nxt  = slot_ptr_r;
    done          = 1'b0;
    rejected      = 1'b0;
    estop         = 1'b0;
    if (rx_byte inside {[dcfp_pkg::CHAR_ZERO:dcfp_pkg::CHAR_NINE]}) begin
      acc_nxt = (acc_prod > {4'd0, dcfp_pkg::ACC_MAX}) ? dcfp_pkg::ACC_MAX
                                                      : acc_prod[dcfp_pkg::ACC_W-1:0];
    end else if (rx_byte == dcfp_pkg::CHAR_SPACE) begin
      slot_nxt[slot_ptr_r] = acc_r;
      slot_ptr_nxt = (slot_ptr_r == dcfp_pkg::SLOT_LAST) ? dcfp_pkg::SLOT_FIRST
                                                         : slot_ptr_r + 1'b1;
      acc_nxt = '0;
    end else if (rx_byte == dcfp_pkg::CHAR_END) begin
      done         = 1'b1;
      rejected     = over_limit;
      slot_ptr_nxt = dcfp_pkg::SLOT_FIRST;
      if (!over_limit) begin
        speed_nxt     = slot_r[0][dcfp_pkg::SPEED_W-1:0];
        direction_nxt = slot_r[1][dcfp_pkg::DIR_W-1:0];
        spin_nxt      = slot_r[2][dcfp_pkg::SPIN_W-1:0];
      end
      acc_nxt = '0;
      for (int i = 0; i < dcfp_pkg::FIELD_COUNT; i++) slot_nxt[i] = '0;
    end else if (rx_byte == dcfp_pkg::CHAR_STOP) begin
      estop         = 1'b1;
      speed_nxt     = '0;
      direction_nxt = '0;
      spin_nxt      = '0;
      acc_nxt       = '0;
      for (int i = 0; i < dcfp_pkg::FIELD_COUNT; i++) slot_nxt[i] = '0;
    end
  end

  always_comb begin
    result.speed          = speed_nxt;
    result.direction      = direction_nxt;
    result.spin           = spin_nxt;
    result.frame_done     = done;
    result.frame_rejected = rejected;
    result.emergency_stop = estop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= '0;
      direction_r <= '0;
      spin_r      <= '0;
      acc_r       <= '0;
      slot_ptr_r  <= dcfp_pkg::SLOT_FIRST;
      for (int i = 0; i < dcfp_pkg::FIELD_COUNT; i++) slot_r[i] <= '0;
    end else if (advance) begin
      speed_r     <= speed_nxt;
      direction_r <= direction_nxt;
      spin_r      <= spin_nxt;
      acc_r       <= acc_nxt;
      slot_ptr_r  <= slot_ptr_nxt;
      slot_r      <= slot_nxt;
    end
  end

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_ptr_r <= dcfp_pkg::SLOT_LAST)
    else $error("slot pointer out of range");

  a_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    advance && rx_byte == dcfp_pkg::CHAR_END |=>
      slot_ptr_r == dcfp_pkg::SLOT_FIRST && acc_r == '0)
    else $error("end of frame did not rewind slots");

  a_stop_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && rx_byte == dcfp_pkg::CHAR_STOP |=>
      speed_r == '0 && direction_r == '0 && spin_r == '0 &&
      slot_ptr_r == $past(slot_ptr_r))
    else $error("stop did not zero command or moved slot pointer");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && result.frame_rejected |=>
      $stable(speed_r) && $stable(direction_r) && $stable(spin_r))
    else $error("rejected frame changed command");

endmodule

// File: hdl/drive_command_frame_parser.sv
// Top level of the drive command frame parser: input register, frame core, result register.
// Depends on dcfp_pkg, dcfp_cfg_regs and dcfp_frame_core.
//
//   channel | ports                                      | direction
//   in      | in_valid, in_ready, in_rx_byte             | byte in
//   out     | out_valid, out_ready, out_speed_out, ...   | command out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | limit write
//
// One byte per cycle while out_ready stays high; beats are held in the result register.
// The per-byte update of the frame core sits between the input and result registers.
// Synchronous active-low reset clears state, limits go to 21/360/360.
// A stalled out beat holds; in_ready drops only while both registers hold a beat.
module drive_command_frame_parser (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dcfp_pkg::SPEED_W-1:0]          out_speed_out,
  output logic [dcfp_pkg::DIR_W-1:0]            out_direction_out,
  output logic [dcfp_pkg::SPIN_W-1:0]           out_spin_out,
  output logic                                  out_frame_done,
  output logic                                  out_frame_rejected,
  output logic                                  out_emergency_stop,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dcfp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dcfp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  dcfp_pkg::result_t out_res_r;
  dcfp_pkg::result_t core_res;
  dcfp_pkg::limits_t limits;
  logic              advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  dcfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  dcfp_frame_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (in_byte_r),
    .limits  (limits),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
    if (advance) out_res_r <= core_res;
  end

  assign out_valid          = out_valid_r;
  assign out_speed_out      = out_res_r.speed;
  assign out_direction_out  = out_res_r.direction;
  assign out_spin_out       = out_res_r.spin;
  assign out_frame_done     = out_res_r.frame_done;
  assign out_frame_rejected = out_res_r.frame_rejected;
  assign out_emergency_stop = out_res_r.emergency_stop;

endmodule

// File: verif/drive_command_frame_parser_tb.sv
// Self-checking testbench for drive_command_frame_parser: byte frames in, command beats out.
// Holds a scoreboard class that predicts every command beat from the accepted bytes.
// Depends on dcfp_pkg and the RTL of the block only.
module drive_command_frame_parser_tb;

  localparam int                             DATA_W        = dcfp_pkg::CFG_DATA_W;
  localparam logic [dcfp_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
  localparam logic [7:0]                     CHAR_LETTER_S = 8'h53;
  localparam logic [7:0]                     CHAR_MINUS    = 8'h2D;
  localparam int                             CYCLE_LIMIT   = 400000;
  localparam int                             PHASE_BYTES   = 285;
  localparam int                             PHASE_COUNT   = 5;

  class frame_scoreboard;
    logic [dcfp_pkg::SPEED_W-1:0] lim_speed;
    logic [dcfp_pkg::DIR_W-1:0]   lim_direction;
    logic [dcfp_pkg::SPIN_W-1:0]  lim_spin;
    logic [dcfp_pkg::SPEED_W-1:0] speed;
    logic [dcfp_pkg::DIR_W-1:0]   direction;
    logic [dcfp_pkg::SPIN_W-1:0]  spin;
    logic [dcfp_pkg::ACC_W-1:0]   number;
    logic [dcfp_pkg::ACC_W-1:0]   slots [dcfp_pkg::FIELD_COUNT];
    dcfp_pkg::slot_idx_t          slot_ptr;
    dcfp_pkg::result_t            command_q [$];
    int                           errors;

    function new();
      lim_speed     = dcfp_pkg::MAX_SPEED_RST;
      lim_direction = dcfp_pkg::MAX_DIRECTION_RST;
      lim_spin      = dcfp_pkg::MAX_SPIN_RST;
      speed         = '0;
      direction     = '0;
      spin          = '0;
      slot_ptr      = dcfp_pkg::SLOT_FIRST;
      errors        = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      number = '0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_limit(logic [dcfp_pkg::CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        dcfp_pkg::CFG_MAX_SPEED:     lim_speed     = data[dcfp_pkg::SPEED_W-1:0];
        dcfp_pkg::CFG_MAX_DIRECTION: lim_direction = data[dcfp_pkg::DIR_W-1:0];
        dcfp_pkg::CFG_MAX_SPIN:      lim_spin      = data[dcfp_pkg::SPIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned       grown;
      dcfp_pkg::result_t cmd;
      cmd = '0;
      if (b >= dcfp_pkg::CHAR_ZERO && b <= dcfp_pkg::CHAR_NINE) begin
        grown  = 32'(number) * 10 + 32'(b - dcfp_pkg::CHAR_ZERO);
        number = (grown > 32'(dcfp_pkg::ACC_MAX)) ? dcfp_pkg::ACC_MAX
                                                  : grown[dcfp_pkg::ACC_W-1:0];
      end else if (b == dcfp_pkg::CHAR_SPACE) begin
        slots[slot_ptr] = number;
        slot_ptr = (slot_ptr == dcfp_pkg::SLOT_LAST) ? dcfp_pkg::SLOT_FIRST
                                                     : slot_ptr + 1'b1;
        number   = '0;
      end else if (b == dcfp_pkg::CHAR_END) begin
        cmd.frame_done = 1'b1;
        slot_ptr = dcfp_pkg::SLOT_FIRST;
        if (slots[0] > lim_speed || slots[1] > lim_direction || slots[2] > lim_spin) begin
          cmd.frame_rejected = 1'b1;
        end else begin
          speed     = slots[0][dcfp_pkg::SPEED_W-1:0];
          direction = slots[1][dcfp_pkg::DIR_W-1:0];
          spin      = slots[2][dcfp_pkg::SPIN_W-1:0];
        end
        clear_frame();
      end else if (b == dcfp_pkg::CHAR_STOP) begin
        cmd.emergency_stop = 1'b1;
        speed     = '0;
        direction = '0;
        spin      = '0;
        clear_frame();
      end
      cmd.speed     = speed;
      cmd.direction = direction;
      cmd.spin      = spin;
      command_q.push_back(cmd);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_command(dcfp_pkg::result_t got);
      dcfp_pkg::result_t want;
      if (command_q.size() == 0) begin
        $display("%0t: command beat with none pending, expected nothing, actual %h",
                 $time, got);
        errors++;
      end else begin
        want = command_q.pop_front();
        check_field("speed", want.speed, got.speed);
        check_field("direction", want.direction, got.direction);
        check_field("spin", want.spin, got.spin);
        check_field("frame_done", want.frame_done, got.frame_done);
        check_field("frame_rejected", want.frame_rejected, got.frame_rejected);
        check_field("emergency_stop", want.emergency_stop, got.emergency_stop);
      end
    endfunction

    function int pending();
      return command_q.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [7:0]                        in_rx_byte = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [dcfp_pkg::SPEED_W-1:0]      out_speed_out;
  logic [dcfp_pkg::DIR_W-1:0]        out_direction_out;
  logic [dcfp_pkg::SPIN_W-1:0]       out_spin_out;
  logic                              out_frame_done;
  logic                              out_frame_rejected;
  logic                              out_emergency_stop;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [dcfp_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [DATA_W-1:0]                 cfg_data = '0;

  frame_scoreboard   sb = new();
  logic [7:0]        tx_bytes [$];
  dcfp_pkg::result_t seen;
  int                in_calm = 0;
  int                out_calm = 0;
  int                cycle_count = 0;

  assign seen = {out_speed_out, out_direction_out, out_spin_out,
                 out_frame_done, out_frame_rejected, out_emergency_stop};

  drive_command_frame_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_speed_out      (out_speed_out),
    .out_direction_out  (out_direction_out),
    .out_spin_out       (out_spin_out),
    .out_frame_done     (out_frame_done),
    .out_frame_rejected (out_frame_rejected),
    .out_emergency_stop (out_emergency_stop),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_byte(in_rx_byte);
      if (out_valid && out_ready) sb.check_command(seen);
    end
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(16, 48);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic void push_number(int unsigned limit);
    int unsigned value;
    int          kind;
    string       digits;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: value = $urandom_range(0, limit);
      4:          value = limit;
      5:          value = limit + 1;
      6:          value = $urandom_range(0, 999);
      7:          value = $urandom_range(0, 65535);
      8:          value = $urandom_range(65536, 9999999);
      default:    value = 0;
    endcase
    if (kind != 9) begin
      if ($urandom_range(0, 9) == 0) tx_bytes.push_back(dcfp_pkg::CHAR_ZERO);
      digits = $sformatf("%0d", value);
      for (int k = 0; k < digits.len(); k++) tx_bytes.push_back(digits[k]);
    end
  endfunction

  function automatic int unsigned field_limit(int f);
    case (f % dcfp_pkg::FIELD_COUNT)
      0:       return sb.lim_speed;
      1:       return sb.lim_direction;
      default: return sb.lim_spin;
    endcase
  endfunction

  function automatic void push_filler();
    case ($urandom_range(0, 2))
      0:       tx_bytes.push_back(CHAR_LETTER_S);
      1:       tx_bytes.push_back(CHAR_MINUS);
      default: tx_bytes.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void push_frame();
    int kind;
    int fields;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 13) begin
      tx_bytes.push_back(dcfp_pkg::CHAR_STOP);
    end else begin
      if (kind < 70) fields = dcfp_pkg::FIELD_COUNT;
      else if (kind < 85) fields = $urandom_range(0, dcfp_pkg::FIELD_COUNT - 1);
      else fields = $urandom_range(dcfp_pkg::FIELD_COUNT + 1, 2 * dcfp_pkg::FIELD_COUNT + 1);
      for (int f = 0; f < fields; f++) begin
        push_number(field_limit(f));
        if ($urandom_range(0, 19) == 0) push_filler();
        tx_bytes.push_back(dcfp_pkg::CHAR_SPACE);
      end
      if ($urandom_range(0, 7) == 0) push_number(field_limit(fields));
      if ($urandom_range(0, 29) == 0) tx_bytes.push_back(dcfp_pkg::CHAR_STOP);
      if ($urandom_range(0, 19) != 0) tx_bytes.push_back(dcfp_pkg::CHAR_END);
    end
  endfunction

  function automatic void load_directed();
    tx_bytes = '{8'h00, 8'hFF,
                 dcfp_pkg::CHAR_NINE, dcfp_pkg::CHAR_NINE, dcfp_pkg::CHAR_NINE,
                 dcfp_pkg::CHAR_NINE, dcfp_pkg::CHAR_NINE,
                 CHAR_LETTER_S, dcfp_pkg::CHAR_SPACE, dcfp_pkg::CHAR_END,
                 dcfp_pkg::CHAR_ZERO + 8'd1, dcfp_pkg::CHAR_SPACE,
                 dcfp_pkg::CHAR_ZERO + 8'd2, dcfp_pkg::CHAR_SPACE,
                 dcfp_pkg::CHAR_ZERO + 8'd3, dcfp_pkg::CHAR_SPACE,
                 dcfp_pkg::CHAR_ZERO + 8'd4, dcfp_pkg::CHAR_SPACE, dcfp_pkg::CHAR_END,
                 dcfp_pkg::CHAR_ZERO + 8'd7, dcfp_pkg::CHAR_SPACE,
                 dcfp_pkg::CHAR_STOP, CHAR_MINUS,
                 dcfp_pkg::CHAR_ZERO + 8'd5, dcfp_pkg::CHAR_SPACE,
                 dcfp_pkg::CHAR_ZERO + 8'd6, dcfp_pkg::CHAR_END};
  endfunction

  task automatic feed_bytes();
    int gap;
    while (tx_bytes.size() > 0) begin
      gap = draw_gap(in_calm);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_rx_byte <= tx_bytes.pop_front();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic program_limits(input logic [DATA_W-1:0] spd,
                                input logic [DATA_W-1:0] dir,
                                input logic [DATA_W-1:0] spn);
    logic [dcfp_pkg::CFG_IDX_W-1:0] idx_list [4];
    logic [DATA_W-1:0]              val_list [4];
    idx_list = '{dcfp_pkg::CFG_MAX_SPEED, dcfp_pkg::CFG_MAX_DIRECTION,
                 dcfp_pkg::CFG_MAX_SPIN, CFG_SPARE};
    val_list = '{spd, dir, spn, DATA_W'($urandom_range(0, 511))};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data  <= val_list[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_limit(idx_list[k], val_list[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin : drain_commands
    int gap;
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin : run_phases
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_directed();
    feed_bytes();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0: program_limits(dcfp_pkg::MAX_SPEED_RST, dcfp_pkg::MAX_DIRECTION_RST,
                          dcfp_pkg::MAX_SPIN_RST);
        1: program_limits('0, '0, '0);
        2: program_limits('1, '1, '1);
        default: program_limits(DATA_W'($urandom_range(0, 511)),
                                DATA_W'($urandom_range(0, 511)),
                                DATA_W'($urandom_range(0, 511)));
      endcase
      while (tx_bytes.size() < PHASE_BYTES) push_frame();
      feed_bytes();
    end
    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
